// ===== design/etai_pkg.sv =====
// etai_pkg: shared types and constants of the eta time integration core
// no dependencies; used by etai_ctrl, etai_dp and eta_time_integration_core
package etai_pkg;

  localparam int MaxObs    = 16;
  localparam int RefDays   = 512;
  localparam int ObsAw     = $clog2(MaxObs);
  localparam int ObsCw     = $clog2(MaxObs + 1);
  localparam int RefAw     = $clog2(RefDays);
  localparam int DayW      = 9;
  localparam int EtW       = 16;
  localparam int RatioFrac = 16;
  localparam int RatioW    = EtW + RatioFrac;
  localparam int WinW      = EtW + RefAw + 1;
  localparam int ProdW     = RatioW + WinW;
  localparam int AccW      = 64;
  localparam int TotalW    = 40;
  localparam int DivCntW   = $clog2(RatioW + 1);

  // configuration register indexes
  localparam logic [1:0] RegEtoFirstDay = 2'd0;
  localparam logic [1:0] RegPeriodStart = 2'd1;
  localparam logic [1:0] RegPeriodEnd   = 2'd2;

  localparam logic KindRef = 1'b0;
  localparam logic KindObs = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [DayW-1:0]  eto_slot;
    logic [EtW-1:0]   eto_value;
    logic             eto_missing;
    logic [EtW-1:0]   eta_value;
    logic [DayW-1:0]  obs_day;
    logic             obs_missing;
    logic             last_obs;
  } in_item_t;

  typedef struct packed {
    logic [TotalW-1:0] total_et;
    logic              result_null;
    logic              saturated;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // accept an input beat
    logic first;     // start of pixel compute, read first observation
    logic cap_first; // capture first observation
    logic rd_cur;    // read reference on current observation day and next observation
    logic chk;       // check reference, start divide, set window bounds
    logic div_run;
    logic win_run;
    logic mul;
    logic acc_adv;   // accumulate product, move to next observation
    logic finish;    // write result register, clear pixel
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic starts;    // input beat is an observation marked last
    logic empty;     // nothing to integrate or pixel already null
    logic cur_bad;
    logic div_done;
    logic win_done;
    logic last_idx;
    logic out_busy;
  } status_t;

endpackage

// ===== design/etai_ctrl.sv =====
// etai_ctrl: sequencer of the eta time integration core
// depends on etai_pkg; drives etai_dp through cmd_t, watches status_t
module etai_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  etai_pkg::status_t st_i,
  output etai_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StFirst = 4'd1;
  localparam logic [3:0] StCapF  = 4'd2;
  localparam logic [3:0] StCur   = 4'd3;
  localparam logic [3:0] StChk   = 4'd4;
  localparam logic [3:0] StDiv   = 4'd5;
  localparam logic [3:0] StWin   = 4'd6;
  localparam logic [3:0] StMul   = 4'd7;
  localparam logic [3:0] StAcc   = 4'd8;
  localparam logic [3:0] StFin   = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (st_i.starts) state_d = StFirst;
        end
      end
      StFirst: begin
        cmd_o.first = 1'b1;
        state_d = st_i.empty ? StFin : StCapF;
      end
      StCapF: begin
        cmd_o.cap_first = 1'b1;
        state_d = StCur;
      end
      StCur: begin
        cmd_o.rd_cur = 1'b1;
        state_d = StChk;
      end
      StChk: begin
        cmd_o.chk = 1'b1;
        state_d = st_i.cur_bad ? StFin : StDiv;
      end
      StDiv: begin
        cmd_o.div_run = 1'b1;
        if (st_i.div_done) state_d = StWin;
      end
      StWin: begin
        cmd_o.win_run = 1'b1;
        if (st_i.win_done) state_d = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d = StAcc;
      end
      StAcc: begin
        cmd_o.acc_adv = 1'b1;
        state_d = st_i.last_idx ? StFin : StCur;
      end
      StFin: begin
        if (!st_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/etai_dp.sv =====
// etai_dp: stores, divider, window walk, multiply-accumulate and result register
// depends on etai_pkg; commanded by etai_ctrl
module etai_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [8:0]           cfg_wdata_i,
  input  etai_pkg::in_item_t   in_item_i,
  input  etai_pkg::cmd_t       cmd_i,
  output etai_pkg::status_t    st_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output etai_pkg::out_item_t  out_item_o
);

  localparam int DayW = etai_pkg::DayW;
  localparam int EtW  = etai_pkg::EtW;

  // configuration
  logic [DayW-1:0] first_q, start_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= DayW'(1);
      start_q <= DayW'(1);
      end_q   <= DayW'(365);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        etai_pkg::RegEtoFirstDay: first_q <= cfg_wdata_i;
        etai_pkg::RegPeriodStart: start_q <= cfg_wdata_i;
        etai_pkg::RegPeriodEnd:   end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // reference store: {null, value}
  logic [EtW:0]               ref_mem [etai_pkg::RefDays];
  logic [EtW:0]               ref_rd_q;
  logic [etai_pkg::RefAw-1:0] ref_raddr;
  logic                       ref_we;

  // observation store: {et, day}
  logic [EtW+DayW-1:0]        obs_mem [etai_pkg::MaxObs];
  logic [EtW+DayW-1:0]        obs_rd_q;
  logic [etai_pkg::ObsAw-1:0] obs_raddr;
  logic                       obs_we;

  logic [etai_pkg::ObsCw-1:0] count_q;
  logic                       pix_null_q;
  logic [etai_pkg::ObsCw-1:0] idx_q;
  logic                       null_res_q;

  logic [DayW-1:0] cur_day_q, prev_day_q, next_day_q;
  logic [EtW-1:0]  cur_et_q, next_et_q;
  logic            cur_in_q;

  logic [etai_pkg::RatioW-1:0]  dvd_q;
  logic [EtW:0]                 rem_q;
  logic [EtW-1:0]               dvs_q;
  logic [etai_pkg::DivCntW-1:0] div_cnt_q;

  logic [DayW:0]              d_q, after_q;
  logic                       pend_q, pend_ok_q;
  logic [etai_pkg::WinW-1:0]  win_q;
  logic [etai_pkg::ProdW-1:0] prod_q;
  logic [etai_pkg::AccW-1:0]  acc_q;

  logic                out_valid_q;
  etai_pkg::out_item_t out_q;

  // day to store slot
  logic [DayW+1:0] cur_off, walk_off;
  logic            walk_ok;
  assign cur_off  = {2'b00, cur_day_q} - {2'b00, first_q};
  assign walk_off = {1'b0, d_q} - {2'b00, first_q};
  assign walk_ok  = !walk_off[DayW+1] && (walk_off < (DayW+2)'(etai_pkg::RefDays));

  assign ref_raddr = cmd_i.win_run ? walk_off[etai_pkg::RefAw-1:0]
                                   : cur_off[etai_pkg::RefAw-1:0];
  assign ref_we = cmd_i.load && (in_item_i.kind == etai_pkg::KindRef) &&
                  ({1'b0, in_item_i.eto_slot} < (DayW+1)'(etai_pkg::RefDays));

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[in_item_i.eto_slot[etai_pkg::RefAw-1:0]] <=
        {in_item_i.eto_missing, in_item_i.eto_value};
    end
    ref_rd_q <= ref_mem[ref_raddr];
  end

  assign obs_we = cmd_i.load && (in_item_i.kind == etai_pkg::KindObs) &&
                  !in_item_i.obs_missing &&
                  (count_q < etai_pkg::ObsCw'(etai_pkg::MaxObs));
  assign obs_raddr = cmd_i.first ? '0 : etai_pkg::ObsAw'(idx_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (obs_we) begin
      obs_mem[count_q[etai_pkg::ObsAw-1:0]] <= {in_item_i.eta_value, in_item_i.obs_day};
    end
    obs_rd_q <= obs_mem[obs_raddr];
  end

  // pixel bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      pix_null_q <= 1'b0;
    end else if (cmd_i.finish) begin
      count_q    <= '0;
      pix_null_q <= 1'b0;
    end else if (cmd_i.load && (in_item_i.kind == etai_pkg::KindObs)) begin
      if (in_item_i.obs_missing) pix_null_q <= 1'b1;
      else if (obs_we) count_q <= count_q + 1'b1;
    end
  end

  // window bounds, computed at the check step
  logic [DayW:0] before_w, after_w, sum_prev, sum_next;
  assign sum_prev = {1'b0, cur_day_q} + {1'b0, prev_day_q};
  assign sum_next = {1'b0, cur_day_q} + {1'b0, obs_rd_q[DayW-1:0]};
  assign before_w = (idx_q == '0) ? {1'b0, start_q} : ({1'b0, sum_prev[DayW:1]} + 1'b1);
  assign after_w  = st_o.last_idx ? {1'b0, end_q} : {1'b0, sum_next[DayW:1]};

  // restoring divider step
  logic [EtW:0] div_trial;
  logic         div_ge;
  assign div_trial = {rem_q[EtW-1:0], dvd_q[etai_pkg::RatioW-1]};
  assign div_ge    = div_trial >= {1'b0, dvs_q};

  logic [etai_pkg::AccW:0] acc_sum;
  assign acc_sum = {1'b0, acc_q} + (etai_pkg::AccW+1)'(prod_q);

  logic [etai_pkg::AccW-etai_pkg::RatioFrac-1:0] shifted;
  assign shifted = acc_q[etai_pkg::AccW-1:etai_pkg::RatioFrac];

  logic cur_bad;
  assign cur_bad = !cur_in_q || ref_rd_q[EtW] || (ref_rd_q[EtW-1:0] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      null_res_q <= 1'b0;
      div_cnt_q  <= '0;
      pend_q     <= 1'b0;
    end else begin
      if (cmd_i.first) begin
        idx_q      <= '0;
        null_res_q <= pix_null_q;
      end
      if (cmd_i.chk) begin
        if (cur_bad) null_res_q <= 1'b1;
        div_cnt_q <= etai_pkg::DivCntW'(etai_pkg::RatioW);
        pend_q    <= 1'b0;
      end
      if (cmd_i.div_run && div_cnt_q != '0) div_cnt_q <= div_cnt_q - 1'b1;
      if (cmd_i.win_run) pend_q <= (d_q < after_q);
      if (cmd_i.acc_adv) idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.first) acc_q <= '0;
    if (cmd_i.cap_first) begin
      cur_et_q  <= obs_rd_q[EtW+DayW-1:DayW];
      cur_day_q <= obs_rd_q[DayW-1:0];
    end
    if (cmd_i.rd_cur) cur_in_q <= !cur_off[DayW+1];
    if (cmd_i.chk) begin
      next_et_q  <= obs_rd_q[EtW+DayW-1:DayW];
      next_day_q <= obs_rd_q[DayW-1:0];
      dvd_q      <= {cur_et_q, etai_pkg::RatioFrac'(0)};
      rem_q      <= '0;
      dvs_q      <= ref_rd_q[EtW-1:0];
      d_q        <= before_w;
      after_q    <= after_w;
      win_q      <= '0;
    end
    if (cmd_i.div_run && div_cnt_q != '0) begin
      rem_q <= div_ge ? (div_trial - {1'b0, dvs_q}) : div_trial;
      dvd_q <= {dvd_q[etai_pkg::RatioW-2:0], div_ge};
    end
    if (cmd_i.win_run) begin
      if (d_q < after_q) d_q <= d_q + 1'b1;
      pend_ok_q <= walk_ok;
      if (pend_q && pend_ok_q && !ref_rd_q[EtW]) begin
        win_q <= win_q + etai_pkg::WinW'(ref_rd_q[EtW-1:0]);
      end
    end
    if (cmd_i.mul) prod_q <= dvd_q * win_q;
    if (cmd_i.acc_adv) begin
      acc_q      <= acc_sum[etai_pkg::AccW] ? '1 : acc_sum[etai_pkg::AccW-1:0];
      prev_day_q <= cur_day_q;
      cur_day_q  <= next_day_q;
      cur_et_q   <= next_et_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (null_res_q) begin
        out_q <= '{total_et: '0, result_null: 1'b1, saturated: 1'b0};
      end else if (shifted[etai_pkg::AccW-etai_pkg::RatioFrac-1:etai_pkg::TotalW] != '0) begin
        out_q <= '{total_et: '1, result_null: 1'b0, saturated: 1'b1};
      end else begin
        out_q <= '{total_et: shifted[etai_pkg::TotalW-1:0], result_null: 1'b0,
                   saturated: 1'b0};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign st_o.starts   = (in_item_i.kind == etai_pkg::KindObs) && in_item_i.last_obs;
  assign st_o.empty    = (count_q == '0) || pix_null_q;
  assign st_o.cur_bad  = cur_bad;
  assign st_o.div_done = (div_cnt_q == '0);
  assign st_o.win_done = !(d_q < after_q) && !pend_q;
  assign st_o.last_idx = ((idx_q + 1'b1) == count_q);
  assign st_o.out_busy = out_valid_q && !out_ready_i;

endmodule

// ===== design/eta_time_integration_core.sv =====
// eta_time_integration_core: top level of the per-pixel actual ET time integration
// depends on etai_pkg, etai_ctrl and etai_dp
//
// usage
// - input channel (in_valid_i/in_ready_o/in_item_i): reference ET day samples
//   (kind 0) and then the pixel's observations (kind 1) in day order
// - a reference beat or an observation without last_obs is taken while idle and
//   the block stays ready, so such beats go back to back
// - an observation with last_obs starts the integration; no beat is taken until
//   the result is in the output register
// - integration steps per stored observation: a current-reference read and a check,
//   the one-bit-per-cycle divider (32 steps, then a done check), a walk over the
//   window days in the reference store, then multiply and accumulate; plus start,
//   first-observation capture and finish steps per pixel
// - output channel (out_valid_o/out_ready_i/out_item_o): one result beat per
//   pixel, held in a register; new beats are taken while it waits, and a
//   following pixel result waits in the final state until the register frees
// - config port: write-only, taken any cycle the block is idle
// - reset clears the control state, the observation count and the pixel null
//   flag; the stores hold no valid bits and must be loaded before use
module eta_time_integration_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [8:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  etai_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output etai_pkg::out_item_t out_item_o
);

  etai_pkg::cmd_t    cmd;
  etai_pkg::status_t st;

  // sequencer
  etai_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // stores and arithmetic
  etai_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
